// ===== sv/fdl_pkg.sv =====
// fdl_pkg: shared constants, register index codes and control types
// for the feedback delay line core and its submodules; no dependencies

package fdl_pkg;

   localparam int CSR_INDEX_BITS    = 8;
   localparam int CSR_DATA_BITS     = 16;
   localparam int SAMPLE_IO_BITS    = 16;
   localparam int GAIN_BITS         = 16;
   localparam int LENGTH_FIELD_BITS = 13;

   localparam logic signed [GAIN_BITS-1:0] FEEDBACK_GAIN_RESET = 16'sh0000;
   localparam logic signed [GAIN_BITS-1:0] DRY_GAIN_RESET      = 16'sh7FFF;
   localparam logic signed [GAIN_BITS-1:0] WET_GAIN_RESET      = 16'sh0000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY_LENGTH  = 8'd0,
      CSR_FEEDBACK_GAIN = 8'd1,
      CSR_DRY_GAIN      = 8'd2,
      CSR_WET_GAIN      = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic advance;
      logic fwd_hit;
   } fdl_ctrl_type;

endpackage

// ===== sv/fdl_store.sv =====
// fdl_store: ring sample memory, one write and one registered read per cycle,
// with a zero fill sweep after reset; no package dependencies

module fdl_store #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic signed [WIDTH-1:0]        rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic signed [WIDTH-1:0]        wr_data,
   output logic                           busy
);

   localparam int AW = $clog2(DEPTH);

   logic signed [WIDTH-1:0] mem [DEPTH];
   logic signed [WIDTH-1:0] rd_data_ff;
   logic                    clr_active_ff;
   logic [AW-1:0]           clr_addr_ff;

   logic                    we;
   logic [AW-1:0]           wa;
   logic signed [WIDTH-1:0] wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_comb begin
      if (clr_active_ff) begin
         we = 1'b1;
         wa = clr_addr_ff;
         wd = '0;
      end else begin
         we = wr_en;
         wa = wr_addr;
         wd = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_active_ff;

endmodule

// ===== sv/fdl_datapath.sv =====
// fdl_datapath: gain multiply, rounding and saturation pipeline with the
// output register; depends on fdl_pkg for widths and the control struct

module fdl_datapath import fdl_pkg::*; #(
   parameter int SB = 16
) (
   input  logic                              clock,
   input  fdl_ctrl_type                      ctrl,
   input  logic signed [SAMPLE_IO_BITS-1:0]  sample_in,
   input  logic                              last_in,
   input  logic signed [SB-1:0]              rd_data,
   input  logic signed [GAIN_BITS-1:0]       feedback_gain,
   input  logic signed [GAIN_BITS-1:0]       dry_gain,
   input  logic signed [GAIN_BITS-1:0]       wet_gain,
   output logic signed [SB-1:0]              stored_out,
   output logic signed [SAMPLE_IO_BITS-1:0]  sample_out,
   output logic                              last_out
);

   localparam int PW = SB + GAIN_BITS;
   localparam int SW = SB + 18;
   localparam logic signed [SW-1:0] RND_HALF = SW'(16384);
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [SB-1:0] clamp(input logic signed [SW-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[SB-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[SB-1:0];
      end
      return v[SB-1:0];
   endfunction

   // b stage
   logic signed [SAMPLE_IO_BITS-1:0] x_b_ff;
   logic                             last_b_ff;
   logic                             fwd_hit_ff;
   logic signed [SB-1:0]             fwd_data_ff;
   logic signed [SB-1:0]             rd_b;
   logic signed [SB-1:0]             x_sat;
   logic signed [PW-1:0]             p_fb_in, p_dry_in, p_wet_in;

   // c stage
   logic signed [SB-1:0]             x_c_ff;
   logic                             last_c_ff;
   logic signed [PW-1:0]             p_fb_ff, p_dry_ff, p_wet_ff;
   logic signed [SW-1:0]             st_sum, mix_sum;
   logic signed [SB-1:0]             stored_c, mix_c;
   logic signed [SW-1:0]             mix_wide;

   // output register
   logic signed [SAMPLE_IO_BITS-1:0] sample_out_ff;
   logic                             last_out_ff;

   always_comb begin
      rd_b     = fwd_hit_ff ? fwd_data_ff : rd_data;
      x_sat    = clamp(SW'(x_b_ff));
      p_fb_in  = rd_b * feedback_gain;
      p_dry_in = x_sat * dry_gain;
      p_wet_in = rd_b * wet_gain;
   end

   always_comb begin
      st_sum   = (SW'(x_c_ff) <<< 15) + SW'(p_fb_ff) + RND_HALF;
      mix_sum  = SW'(p_dry_ff) + SW'(p_wet_ff) + RND_HALF;
      stored_c = clamp(st_sum >>> 15);
      mix_c    = clamp(mix_sum >>> 15);
      mix_wide = SW'($unsigned(mix_c));
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         x_b_ff        <= sample_in;
         last_b_ff     <= last_in;
         fwd_hit_ff    <= ctrl.fwd_hit;
         fwd_data_ff   <= stored_c;
         x_c_ff        <= x_sat;
         last_c_ff     <= last_b_ff;
         p_fb_ff       <= p_fb_in;
         p_dry_ff      <= p_dry_in;
         p_wet_ff      <= p_wet_in;
         sample_out_ff <= mix_wide[SAMPLE_IO_BITS-1:0];
         last_out_ff   <= last_c_ff;
      end
   end

   assign stored_out = stored_c;
   assign sample_out = sample_out_ff;
   assign last_out   = last_out_ff;

endmodule

// ===== sv/feedback_delay_line_core.sv =====
// feedback_delay_line_core: feedback comb filter on a ring sample memory
// an accepted req moves through the b, c and output registers to rsp_valid;
// throughput: 1 transaction per cycle while rsp_ready keeps up; with delay
// length 1 or 2 the read of a sample hits the write of the one just ahead and
// req_ready stays low while that one is in the b stage; reset: synchronous;
// memory zero filled after reset, req_ready low, csr writes taken throughout

module feedback_delay_line_core import fdl_pkg::*; #(
   parameter int MAX_DELAY   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_IO_BITS-1:0]  req_sample_in,
   input  logic                              req_frame_last_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_IO_BITS-1:0]  rsp_sample_out,
   output logic                              rsp_frame_last_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]          csr_data
);

   localparam int AW = $clog2(MAX_DELAY);
   localparam int LW = AW + 1;

   function automatic logic [AW-1:0] advance_pos(input logic [AW-1:0] p,
                                                 input logic [LW-1:0] len);
      logic [LW-1:0] n;
      n = {1'b0, p} + LW'(1);
      return (n >= len) ? '0 : n[AW-1:0];
   endfunction

   logic [LW-1:0]                 delay_length_ff, delay_length_in;
   logic signed [GAIN_BITS-1:0]   feedback_gain_ff, feedback_gain_in;
   logic signed [GAIN_BITS-1:0]   dry_gain_ff, dry_gain_in;
   logic signed [GAIN_BITS-1:0]   wet_gain_ff, wet_gain_in;
   logic [AW-1:0]                 read_pos_ff, read_pos_in;
   logic [AW-1:0]                 write_pos_ff, write_pos_in;

   logic                          b_valid_ff, c_valid_ff, out_valid_ff;
   logic [AW-1:0]                 b_wpos_ff, c_wpos_ff;

   logic                          csr_write;
   logic                          accept;
   logic                          advance;
   logic                          hazard;
   logic                          busy;
   logic [31:0]                   len_wide;
   logic [LW-1:0]                 len_new;
   fdl_ctrl_type                  ctrl;

   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic signed [SAMPLE_BITS-1:0] stored;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign advance   = !out_valid_ff || rsp_ready;
   assign hazard    = b_valid_ff && (b_wpos_ff == read_pos_ff);
   assign req_ready = !busy && advance && !hazard;
   assign accept    = req_valid && req_ready;

   assign ctrl.advance = advance;
   assign ctrl.fwd_hit = c_valid_ff && (c_wpos_ff == read_pos_ff);

   always_comb begin
      len_wide = 32'(csr_data[LENGTH_FIELD_BITS-1:0]);
      if (len_wide > 32'(MAX_DELAY)) begin
         len_wide = 32'(MAX_DELAY);
      end
      if (len_wide == 32'd0) begin
         len_wide = 32'd1;
      end
      len_new = LW'(len_wide);
   end

   always_comb begin
      delay_length_in  = delay_length_ff;
      feedback_gain_in = feedback_gain_ff;
      dry_gain_in      = dry_gain_ff;
      wet_gain_in      = wet_gain_ff;
      read_pos_in      = read_pos_ff;
      write_pos_in     = write_pos_ff;
      priority if (csr_write) begin
         unique case (csr_index)
            CSR_DELAY_LENGTH: begin
               delay_length_in = len_new;
               if ({1'b0, read_pos_ff} >= len_new) begin
                  read_pos_in = '0;
               end
               if ({1'b0, write_pos_ff} >= len_new) begin
                  write_pos_in = AW'(len_new - LW'(1));
               end
            end
            CSR_FEEDBACK_GAIN: feedback_gain_in = csr_data[GAIN_BITS-1:0];
            CSR_DRY_GAIN:      dry_gain_in      = csr_data[GAIN_BITS-1:0];
            CSR_WET_GAIN:      wet_gain_in      = csr_data[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end else if (accept) begin
         read_pos_in  = advance_pos(read_pos_ff, delay_length_ff);
         write_pos_in = advance_pos(write_pos_ff, delay_length_ff);
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff  <= LW'(MAX_DELAY);
         feedback_gain_ff <= FEEDBACK_GAIN_RESET;
         dry_gain_ff      <= DRY_GAIN_RESET;
         wet_gain_ff      <= WET_GAIN_RESET;
         read_pos_ff      <= '0;
         write_pos_ff     <= AW'(MAX_DELAY - 1);
      end else begin
         delay_length_ff  <= delay_length_in;
         feedback_gain_ff <= feedback_gain_in;
         dry_gain_ff      <= dry_gain_in;
         wet_gain_ff      <= wet_gain_in;
         read_pos_ff      <= read_pos_in;
         write_pos_ff     <= write_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff   <= accept;
         c_valid_ff   <= b_valid_ff;
         out_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_wpos_ff <= write_pos_ff;
         c_wpos_ff <= b_wpos_ff;
      end
   end

   fdl_store #(
      .DEPTH (MAX_DELAY),
      .WIDTH (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (read_pos_ff),
      .rd_data (rd_data),
      .wr_en   (advance && c_valid_ff),
      .wr_addr (c_wpos_ff),
      .wr_data (stored),
      .busy    (busy)
   );

   fdl_datapath #(
      .SB (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .ctrl          (ctrl),
      .sample_in     (req_sample_in),
      .last_in       (req_frame_last_in),
      .rd_data       (rd_data),
      .feedback_gain (feedback_gain_ff),
      .dry_gain      (dry_gain_ff),
      .wet_gain      (wet_gain_ff),
      .stored_out    (stored),
      .sample_out    (rsp_sample_out),
      .last_out      (rsp_frame_last_out)
   );

   assign rsp_valid = out_valid_ff;

endmodule

// ===== sv/fdl_checker.sv =====
// fdl_checker: port level assertions for feedback_delay_line_core and the
// bind that attaches them; depends on fdl_pkg for the sample width

module fdl_checker import fdl_pkg::*; (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [SAMPLE_IO_BITS-1:0]  rsp_sample_out,
   input logic                              rsp_frame_last_out
);

   logic [2:0] pending_ff;
   logic       req_xact;
   logic       rsp_xact;

   assign req_xact = req_valid && req_ready;
   assign rsp_xact = rsp_valid && rsp_ready;

   // transactions accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 3'(req_xact) - 3'(rsp_xact);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_frame_last_out))
      else $error("rsp transaction changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("rsp transaction without a matching req transaction");

   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more transactions in flight than pipeline stages");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("req_ready high during memory fill after reset");

endmodule

bind feedback_delay_line_core fdl_checker u_fdl_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for feedback_delay_line_core, a comb filter on a ring store
// depends on fdl_pkg for register index codes, reset gains and port widths

module tb;
   import fdl_pkg::*;

   localparam int DELAY_DEPTH = 4096;
   localparam int SAMPLE_W    = 16;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 45;
   localparam int DRAIN_WAIT  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LOW = 8'h04;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_TOP = 8'hFF;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [15:0]               data;
      logic                      last;
      logic                      typed;
      logic [15:0]               want;
   } stim_row_type;

   typedef struct packed {
      logic signed [SAMPLE_IO_BITS-1:0] sample;
      logic                             last;
   } mix_result_type;

   localparam stim_row_type DIRECTED_ROWS [34] = '{
      '{ROW_SAMPLE, 8'h00, 16'h7FFF, 1'b0, 1'b1, 16'h7FFE},
      '{ROW_SAMPLE, 8'h00, 16'h8000, 1'b1, 1'b1, 16'h8001},
      '{ROW_SAMPLE, 8'h00, 16'h0000, 1'b0, 1'b1, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h0001, 1'b1, 1'b1, 16'h0001},
      '{ROW_SAMPLE, 8'h00, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
      '{ROW_CSR, CSR_DELAY_LENGTH, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_FEEDBACK_GAIN, 16'h8000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_WET_GAIN, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h3039, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h8000, 1'b1, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h0100, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_UNUSED_LOW, 16'h1234, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_UNUSED_TOP, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_DELAY_LENGTH, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_DRY_GAIN, 16'h8000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_WET_GAIN, 16'h8000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h8000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_DELAY_LENGTH, 16'h0002, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_FEEDBACK_GAIN, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_DRY_GAIN, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h8000, 1'b1, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_DELAY_LENGTH, 16'h1001, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_DELAY_LENGTH, 16'h1000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h5555, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'hAAAA, 1'b1, 1'b0, 16'h0000},
      '{ROW_CSR, CSR_DELAY_LENGTH, 16'h0003, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h0001, 1'b1, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 8'h00, 16'h8000, 1'b0, 1'b0, 16'h0000}
   };

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic signed [SAMPLE_IO_BITS-1:0] req_sample_in;
   logic                             req_frame_last_in;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic signed [SAMPLE_IO_BITS-1:0] rsp_sample_out;
   logic                             rsp_frame_last_out;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [CSR_INDEX_BITS-1:0]        csr_index;
   logic [CSR_DATA_BITS-1:0]         csr_data;

   feedback_delay_line_core #(
      .MAX_DELAY   (DELAY_DEPTH),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_in      (req_sample_in),
      .req_frame_last_in  (req_frame_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_frame_last_out (rsp_frame_last_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // comb filter state as the block should hold it
   logic signed [15:0] ring_model [DELAY_DEPTH];
   int                 rd_idx;
   int                 wr_idx;
   int                 len_model;
   logic signed [15:0] fb_model;
   logic signed [15:0] dry_model;
   logic signed [15:0] wet_model;

   mix_result_type mix_expect_q [$];
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   int             samples_sent = 0;
   int             results_checked = 0;
   int             csr_writes = 0;
   int             error_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic logic signed [15:0] round_sat(longint acc);
      longint v;
      v = (acc + 64'sd16384) >>> 15;
      if (v > 64'sd32767) return 16'sh7FFF;
      if (v < -64'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic int ring_next(int p);
      return (p + 1 >= len_model) ? 0 : p + 1;
   endfunction

   task automatic comb_reset();
      foreach (ring_model[i]) ring_model[i] = '0;
      len_model = DELAY_DEPTH;
      fb_model  = FEEDBACK_GAIN_RESET;
      dry_model = DRY_GAIN_RESET;
      wet_model = WET_GAIN_RESET;
      rd_idx    = 0;
      wr_idx    = len_model - 1;
   endtask

   task automatic comb_config(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] data);
      int n;
      case (idx)
         CSR_DELAY_LENGTH: begin
            n = int'(data[LENGTH_FIELD_BITS-1:0]);
            if (n > DELAY_DEPTH) n = DELAY_DEPTH;
            if (n == 0) n = 1;
            len_model = n;
            if (rd_idx >= n) rd_idx = 0;
            if (wr_idx >= n) wr_idx = n - 1;
         end
         CSR_FEEDBACK_GAIN: fb_model = data;
         CSR_DRY_GAIN:      dry_model = data;
         CSR_WET_GAIN:      wet_model = data;
         default: ;
      endcase
   endtask

   task automatic comb_step(input logic signed [15:0] x, output logic signed [15:0] y);
      logic signed [15:0] tap;
      longint             acc;
      tap = ring_model[rd_idx];
      rd_idx = ring_next(rd_idx);
      acc = longint'(x) * 64'sd32768 + longint'(tap) * longint'(fb_model);
      ring_model[wr_idx] = round_sat(acc);
      wr_idx = ring_next(wr_idx);
      acc = longint'(x) * longint'(dry_model) + longint'(tap) * longint'(wet_model);
      y = round_sat(acc);
   endtask

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   always @(posedge clock) begin
      mix_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mix_expect_q.size() == 0) begin
            flag_error($sformatf("unexpected result sample %0d last %0b",
                                 rsp_sample_out, rsp_frame_last_out));
         end else begin
            got = mix_expect_q.pop_front();
            results_checked++;
            if (rsp_sample_out !== got.sample)
               flag_error($sformatf("result %0d sample: expected %0d, got %0d",
                                    results_checked, got.sample, rsp_sample_out));
            if (rsp_frame_last_out !== got.last)
               flag_error($sformatf("result %0d frame_last: expected %0b, got %0b",
                                    results_checked, got.last, rsp_frame_last_out));
         end
      end
   end

   task automatic push_sample(logic [15:0] x, logic last, logic typed, logic [15:0] want);
      mix_result_type     r;
      logic signed [15:0] y;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_in     <= x;
      req_frame_last_in <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      comb_step(x, y);
      r.sample = typed ? want : y;
      r.last   = last;
      mix_expect_q.push_back(r);
      samples_sent++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] data);
      req_valid <= 1'b0;
      while (mix_expect_q.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      comb_config(idx, data);
      csr_writes++;
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] phase_length(int ph);
      case (ph)
         0: return 16'h0001;
         1: return 16'h0002;
         2: return 16'h1000;
         3: return 16'hE005;
         4: return 16'($urandom_range(3, 64));
         5: return 16'($urandom_range(65, 600));
         6: return 16'hFFFF;
         7: return 16'($urandom_range(1, 16));
         default: return 16'($urandom_range(1, DELAY_DEPTH));
      endcase
   endfunction

   initial begin
      stim_row_type row;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample_in     = '0;
      req_frame_last_in = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      comb_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 28;
      rx_idle_pct = 73;
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CSR) write_reg(row.index, row.data);
         else push_sample(row.data, row.last, row.typed, row.want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 3) begin
            tx_idle_pct = 28;
            rx_idle_pct = 73;
         end else if (ph < 6) begin
            tx_idle_pct = 73;
            rx_idle_pct = 28;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_reg(CSR_DELAY_LENGTH, phase_length(ph));
         write_reg(CSR_FEEDBACK_GAIN, pick_gain());
         write_reg(CSR_DRY_GAIN, pick_gain());
         write_reg(CSR_WET_GAIN, pick_gain());
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 1 && k == 20) begin
               // hold off until the pipeline has drained
               req_valid <= 1'b0;
               do @(posedge clock); while (mix_expect_q.size() != 0);
            end
            push_sample(pick_sample(), ($urandom_range(3) == 0), 1'b0, 16'h0000);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (mix_expect_q.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Summary: %0d samples sent, %0d results checked, %0d register writes",
               samples_sent, results_checked, csr_writes);
      $display("Summary: delay lengths 1 to %0d with clamping, extreme gains, %0d mismatches",
               DELAY_DEPTH, error_count);
      if (error_count == 0 && mix_expect_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
